// File: rtl/line_length_filter_defines.svh
// Assertion macros shared by the line length filter RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef LINE_LENGTH_FILTER_DEFINES_SVH
`define LINE_LENGTH_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LLF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line length filter check failed");

// The consequent must hold in the cycle after the antecedent.
`define LLF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line length filter check failed");

`endif

// File: rtl/llf_pkg.sv
// Types and constants of the line length filter.
// Depends on nothing; used by the result buffer and the top level.
package llf_pkg;

   localparam logic [7:0]  NEWLINE_CODE = 8'd10;
   localparam logic [7:0]  DOT_CODE     = 8'd46;
   localparam logic [7:0]  ZERO_CODE    = 8'd0;
   localparam logic [15:0] LENGTH_MAX   = 16'hFFFF;

   localparam logic [1:0] CSR_MIN_LENGTH   = 2'd0;
   localparam logic [1:0] CSR_MAX_LENGTH   = 2'd1;
   localparam logic [1:0] CSR_MAX_LIMIT_ON = 2'd2;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_LEVEL_W = 3;

   typedef logic [RSP_LEVEL_W-1:0] rsp_level_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_line;
   } rsp_word_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } rsp_push_type;

endpackage

// File: rtl/llf_line_ram.sv
// Line store of the line length filter: one write port, one registered read port.
// Depends on nothing.
module llf_line_ram #(
   parameter int DEPTH = 60,
   parameter int AW = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/llf_rsp_buf.sv
// Result buffer of the line length filter: a small queue in front of the rsp port.
// Depends on llf_pkg.
module llf_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  llf_pkg::rsp_push_type push,
   output llf_pkg::rsp_level_type level,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output llf_pkg::rsp_word_type rsp_word
);

   import llf_pkg::*;

   rsp_word_type         mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   rsp_level_type        level_ff, level_in;
   logic                 pop;

   assign pop = (level_ff != '0) && !rsp_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in = level_ff;
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (!push.valid && pop) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.word;
      end
   end

   assign level = level_ff;
   assign rsp_valid = (level_ff != '0);
   assign rsp_word = mem_ff[rd_ptr_ff];

endmodule

// File: rtl/line_length_filter.sv
// Top level of the line length filter: counters, replay sequencer and register file.
// Depends on llf_pkg, llf_line_ram, llf_rsp_buf and line_length_filter_defines.svh.
//
// The filter takes one byte per cycle while a line is being collected; the first
// LINE_KEEP bytes go into a line store with one write and one read port and the line
// length counts up to 65535. A newline that passes the length test starts a replay:
// the kept bytes are read back from the store one per cycle, while there is room, into
// a four-word result queue, followed by three dots when the line was cut and by the
// newline marked last. A passing newline holds the input until that newline word is
// queued; a failing newline does not. A kept zero byte ends the read back early.
// req_stall stays high during the replay, since the store is read then and the next
// line would overwrite it. Configuration may be written at any time the block is
// idle; csr_ready is always high.
module line_length_filter #(
   parameter int LINE_KEEP = 60
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_line,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   import llf_pkg::*;
   `include "line_length_filter_defines.svh"

   localparam int KW = $clog2(LINE_KEEP + 1);
   localparam int AW = (LINE_KEEP > 1) ? $clog2(LINE_KEEP) : 1;
   localparam logic [KW-1:0] KEEP_LIMIT = KW'(LINE_KEEP);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_KEPT = 3'b010,
      ST_TAIL = 3'b100
   } state_type;

   state_type     state_ff, state_in;
   logic [KW-1:0] kept_ff, kept_in;
   logic [15:0]   len_ff, len_in;
   logic [KW-1:0] rd_idx_ff, rd_idx_in;
   logic          pend_ff, pend_in;
   logic          dots_ff, dots_in;
   logic [1:0]    tail_ff, tail_in;
   logic [15:0]   min_ff;
   logic [15:0]   max_ff;
   logic          lim_ff;

   logic          req_acc;
   logic          is_nl;
   logic          pass;
   logic          ram_we;
   logic          rd_issue;
   logic [7:0]    rd_data;
   logic [RSP_LEVEL_W:0] credit_used;
   rsp_push_type  push;
   rsp_level_type level;
   rsp_word_type  rsp_word;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc = req_valid && !req_stall;
   assign is_nl = (req_in_byte == NEWLINE_CODE);
   assign pass = (len_ff >= min_ff) && (!lim_ff || (len_ff <= max_ff));
   assign ram_we = req_acc && !is_nl && (kept_ff < KEEP_LIMIT);
   assign credit_used = (RSP_LEVEL_W + 1)'(level) + (RSP_LEVEL_W + 1)'(pend_ff);
   assign rd_issue = (state_ff == ST_KEPT) && (rd_idx_ff < kept_ff)
      && (credit_used < (RSP_LEVEL_W + 1)'(RSP_DEPTH));

   always_comb begin
      state_in = state_ff;
      kept_in = kept_ff;
      len_in = len_ff;
      rd_idx_in = rd_idx_ff;
      dots_in = dots_ff;
      tail_in = tail_ff;
      pend_in = rd_issue;
      push.valid = 1'b0;
      push.word.out_byte = rd_data;
      push.word.last_of_line = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (!is_nl) begin
                  if (ram_we) begin
                     kept_in = kept_ff + 1'b1;
                  end
                  if (len_ff != LENGTH_MAX) begin
                     len_in = len_ff + 1'b1;
                  end
               end else if (pass) begin
                  state_in = ST_KEPT;
                  rd_idx_in = '0;
                  dots_in = (len_ff > 16'(kept_ff));
               end else begin
                  kept_in = '0;
                  len_in = '0;
               end
            end
         end
         ST_KEPT: begin
            if (rd_issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (pend_ff && (rd_data != ZERO_CODE)) begin
               push.valid = 1'b1;
            end
            if ((pend_ff && (rd_data == ZERO_CODE)) ||
                (!pend_ff && (rd_idx_ff == kept_ff))) begin
               state_in = ST_TAIL;
               tail_in = dots_ff ? 2'd0 : 2'd3;
            end
         end
         ST_TAIL: begin
            if (level < rsp_level_type'(RSP_DEPTH)) begin
               push.valid = 1'b1;
               tail_in = tail_ff + 1'b1;
               if (tail_ff == 2'd3) begin
                  push.word.out_byte = NEWLINE_CODE;
                  push.word.last_of_line = 1'b1;
                  state_in = ST_IDLE;
                  kept_in = '0;
                  len_in = '0;
               end else begin
                  push.word.out_byte = DOT_CODE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kept_ff <= '0;
         len_ff <= '0;
         pend_ff <= 1'b0;
         min_ff <= '0;
         max_ff <= '0;
         lim_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         kept_ff <= kept_in;
         len_ff <= len_in;
         pend_ff <= pend_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MIN_LENGTH: min_ff <= csr_data;
               CSR_MAX_LENGTH: max_ff <= csr_data;
               CSR_MAX_LIMIT_ON: lim_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      dots_ff <= dots_in;
      tail_ff <= tail_in;
   end

   assign csr_ready = 1'b1;

   llf_line_ram #(
      .DEPTH(LINE_KEEP),
      .AW(AW)
   ) u_line_ram (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(kept_ff[AW-1:0]),
      .wr_data(req_in_byte),
      .rd_en(rd_issue),
      .rd_addr(rd_idx_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   llf_rsp_buf u_rsp_buf (
      .clock(clock),
      .reset(reset),
      .push(push),
      .level(level),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   assign rsp_out_byte = rsp_word.out_byte;
   assign rsp_last_of_line = rsp_word.last_of_line;

   `LLF_ASSERT_NOW(a_credit, clock, reset, 1'b1,
      credit_used <= (RSP_LEVEL_W + 1)'(RSP_DEPTH))
   `LLF_ASSERT_NOW(a_replay_bound, clock, reset, state_ff == ST_KEPT, rd_idx_ff <= kept_ff)
   `LLF_ASSERT_NEXT(a_last_ends, clock, reset, push.valid && push.word.last_of_line,
      state_ff == ST_IDLE && kept_ff == '0 && len_ff == '0)
   `LLF_ASSERT_NEXT(a_fail_clears, clock, reset, req_acc && is_nl && !pass,
      state_ff == ST_IDLE && kept_ff == '0 && len_ff == '0)

endmodule

// File: tb/line_length_filter_checker.sv
// Checker for the line length filter: watches the byte, result and register channels.
// Predicts the emitted words of every line and compares them in order; needs llf_pkg.
module line_length_filter_checker #(
   parameter int LINE_KEEP = 60
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_last_of_line,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending_words
);
   timeunit 1ns;
   timeprecision 1ps;
   import llf_pkg::*;

   logic [7:0]   kept_bytes [LINE_KEEP];
   int unsigned  kept_len;
   logic [15:0]  line_len;
   logic [15:0]  min_len_cfg;
   logic [15:0]  max_len_cfg;
   logic         max_on_cfg;
   rsp_word_type expected_words [$];
   int           errors;

   task automatic push_word(input logic [7:0] value, input logic last);
      expected_words.push_back('{out_byte: value, last_of_line: last});
   endtask

   task automatic filter_byte(input logic [7:0] value);
      logic passes;
      logic stopped;
      int   k;
      if (value != NEWLINE_CODE) begin
         if (kept_len < LINE_KEEP) begin
            kept_bytes[kept_len] = value;
            kept_len++;
         end
         if (line_len != LENGTH_MAX) begin
            line_len++;
         end
      end else begin
         passes = (line_len >= min_len_cfg) && (!max_on_cfg || line_len <= max_len_cfg);
         if (passes) begin
            stopped = 1'b0;
            for (k = 0; k < kept_len; k++) begin
               if (kept_bytes[k] == ZERO_CODE) begin
                  stopped = 1'b1;
               end
               if (!stopped) begin
                  push_word(kept_bytes[k], 1'b0);
               end
            end
            if (line_len > kept_len) begin
               repeat (3) push_word(DOT_CODE, 1'b0);
            end
            push_word(NEWLINE_CODE, 1'b1);
         end
         kept_len = 0;
         line_len = '0;
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         kept_len = 0;
         line_len = '0;
         min_len_cfg = '0;
         max_len_cfg = '0;
         max_on_cfg = 1'b0;
         expected_words.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIN_LENGTH: begin
                  min_len_cfg = csr_data;
               end
               CSR_MAX_LENGTH: begin
                  max_len_cfg = csr_data;
               end
               CSR_MAX_LIMIT_ON: begin
                  max_on_cfg = csr_data[0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            filter_byte(req_in_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word: out_byte %0d, last_of_line %0d",
                      rsp_out_byte, rsp_last_of_line);
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (want.out_byte !== rsp_out_byte) begin
                  $error("out_byte mismatch: expected %0d, actual %0d",
                         want.out_byte, rsp_out_byte);
                  errors++;
               end
               if (want.last_of_line !== rsp_last_of_line) begin
                  $error("last_of_line mismatch: expected %0d, actual %0d",
                         want.last_of_line, rsp_last_of_line);
                  errors++;
               end
            end
         end
      end
      fail_count = errors;
      pending_words = expected_words.size();
   end

endmodule

// File: tb/tb.sv
// Top of the line length filter testbench: clock, reset, byte and register stimulus.
// Needs llf_pkg, line_length_filter and line_length_filter_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import llf_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_line;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;
   logic        calm = 1'b0;
   logic        hold_rsp = 1'b0;
   int          fail_count;
   int          pending_words;

   line_length_filter u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_line (rsp_last_of_line),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   line_length_filter_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_line (rsp_last_of_line),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .pending_words    (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("line_length_filter test failed");
      $finish;
   end

   // The result side takes one word per draw; a hold request stalls it for a long stretch.
   initial begin
      int wait_cycles;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         wait_cycles = calm ? 0 : $urandom_range(0, 9);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= value;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_line(input int len);
      int         i;
      logic [7:0] value;
      for (i = 0; i < len; i++) begin
         do value = 8'($urandom_range(0, 255)); while (value == NEWLINE_CODE);
         if ($urandom_range(0, 15) == 0) begin
            value = ZERO_CODE;
         end
         send_byte(value);
      end
      send_byte(NEWLINE_CODE);
   endtask

   task automatic wait_csr();
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_limits(input logic [15:0] min_len, input logic [15:0] max_len,
                             input logic max_on);
      drain();
      csr_valid <= 1'b1;
      csr_index <= CSR_MIN_LENGTH;
      csr_data <= min_len;
      wait_csr();
      csr_index <= CSR_MAX_LENGTH;
      csr_data <= max_len;
      wait_csr();
      csr_index <= CSR_MAX_LIMIT_ON;
      csr_data <= {15'd0, max_on};
      wait_csr();
      csr_valid <= 1'b0;
   endtask

   task automatic random_lines(input int byte_budget);
      int sent;
      int len;
      int pick;
      sent = 0;
      while (sent < byte_budget) begin
         calm = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            len = $urandom_range(0, 20);
         end else if (pick < 9) begin
            len = $urandom_range(55, 66);
         end else begin
            len = $urandom_range(67, 130);
         end
         send_line(len);
         sent += len + 1;
      end
      calm = 1'b0;
   endtask

   initial begin
      logic [7:0] opening [15];
      int         i;
      opening = '{NEWLINE_CODE,
                  ZERO_CODE, 8'hFF, NEWLINE_CODE,
                  8'hFF, 8'h01, ZERO_CODE, 8'h7F, NEWLINE_CODE,
                  8'h55, 8'hAA, 8'h0B, 8'h09, 8'h80, NEWLINE_CODE};
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = '0;
      csr_valid = 1'b0;
      csr_index = CSR_MIN_LENGTH;
      csr_data = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < 15; i++) begin
         send_byte(opening[i]);
      end

      set_limits(16'd0, LENGTH_MAX, 1'b0);
      send_line(60);
      send_line(61);
      hold_rsp = 1'b1;
      send_line(12);
      send_line(5);
      random_lines(30);

      set_limits(16'd5, 16'd20, 1'b1);
      send_line(4);
      send_line(5);
      send_line(20);
      send_line(21);

      set_limits(16'd0, 16'd0, 1'b1);
      send_line(0);
      send_line(1);

      set_limits(16'($urandom_range(0, 40)), 16'($urandom_range(0, 80)),
                 1'($urandom_range(0, 1)));
      random_lines(30);

      set_limits(LENGTH_MAX, 16'd0, 1'b0);
      send_line(3);

      drain();
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending_words == 0) begin
         $display("line_length_filter test passed");
      end else begin
         $display("line_length_filter test failed");
      end
      $finish;
   end

endmodule
